### design/fijm_pkg.sv
// fijm_pkg: shared types and constants of the frame interval jitter monitor
// controller states, command and status groups, register codes, reset values
// no dependencies
package fijm_pkg;

   localparam int DATA_W      = 32;
   localparam int SUM_W       = 48;
   localparam int CFG_W       = 20;
   localparam int COUNT_OUT_W = 11;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_THRESH  = 1'b1;

   localparam logic [CFG_W-1:0]  FRAME_PERIOD_RST = 20'd10000;
   localparam logic [CFG_W-1:0]  WARN_THRESH_RST  = 20'd1000;
   localparam logic [DATA_W-1:0] JIT_MIN_START    = 32'h000F_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RECORD,
      ST_JIT_MAX,
      ST_JIT_REC,
      ST_DIVIDE,
      ST_DELIVER
   } fijm_state_type;

   typedef struct packed {
      logic capture;
      logic first_arr;
      logic calc_iv;
      logic rec_iv;
      logic calc_jmax;
      logic rec_jit;
      logic div_start;
      logic load_out;
   } fijm_cmd_type;

   typedef struct packed {
      logic eot;
      logic full;
      logic started;
      logic count_ge2;
      logic div_done;
      logic out_free;
   } fijm_stat_type;

endpackage

### design/fijm_div.sv
// fijm_div: restoring divider, one quotient bit per cycle
// standalone, used by fijm_dp for the report average
module fijm_div #(
   parameter int DIVIDEND_W = 48,
   parameter int DIVISOR_W  = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);
   localparam int SW = $clog2(DIVIDEND_W);
   localparam logic [SW-1:0] LAST_STEP = SW'(DIVIDEND_W - 1);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in, divisor_ff;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [SW-1:0]         step_ff;
   logic                  busy_ff, done_ff;
   logic [DIVISOR_W:0]    trial, diff;
   logic                  fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits   = trial >= {1'b0, divisor_ff};
      diff   = trial - {1'b0, divisor_ff};
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
         step_ff    <= '0;
         busy_ff    <= 1'b1;
         done_ff    <= 1'b0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff + SW'(1);
         if (step_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

### design/fijm_ctrl.sv
// fijm_ctrl: sequencer of the frame interval jitter monitor
// depends on fijm_pkg for states, commands and status
module fijm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fijm_pkg::fijm_stat_type stat,
   output fijm_pkg::fijm_cmd_type  cmd
);
   import fijm_pkg::*;

   fijm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (stat.eot) begin
               state_in = stat.count_ge2 ? ST_DIVIDE : ST_DELIVER;
            end else if (stat.full || !stat.started) begin
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_RECORD;
            end
         end
         ST_RECORD:  state_in = ST_JIT_MAX;
         ST_JIT_MAX: state_in = ST_JIT_REC;
         ST_JIT_REC: state_in = ST_DELIVER;
         ST_DIVIDE: begin
            if (stat.div_done) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            if (stat.eot) begin
               cmd.div_start = stat.count_ge2;
            end else if (!stat.full) begin
               cmd.first_arr = !stat.started;
               cmd.calc_iv   = stat.started;
            end
         end
         ST_RECORD:  cmd.rec_iv    = 1'b1;
         ST_JIT_MAX: cmd.calc_jmax = 1'b1;
         ST_JIT_REC: cmd.rec_jit   = 1'b1;
         ST_DIVIDE:  cmd           = '0;
         ST_DELIVER: cmd.load_out  = stat.out_free;
         default:    cmd           = '0;
      endcase
   end
endmodule

### design/fijm_dp.sv
// fijm_dp: statistics registers, jitter arithmetic, config and result word
// depends on fijm_pkg and fijm_div
module fijm_dp #(
   parameter int MAX_INTERVALS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fijm_pkg::fijm_cmd_type                cmd,
   output fijm_pkg::fijm_stat_type               stat,
   input  logic                                  csr_wr_en,
   input  logic [fijm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fijm_pkg::CFG_W-1:0]            csr_wdata,
   input  logic [fijm_pkg::DATA_W-1:0]           req_arrival_usec,
   input  logic                                  req_end_of_test,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [fijm_pkg::DATA_W-1:0]           rsp_interval_usec,
   output logic [fijm_pkg::DATA_W-1:0]           rsp_min_interval,
   output logic [fijm_pkg::DATA_W-1:0]           rsp_max_interval,
   output logic [fijm_pkg::DATA_W-1:0]           rsp_min_jitter,
   output logic [fijm_pkg::DATA_W-1:0]           rsp_max_jitter,
   output logic [fijm_pkg::DATA_W-1:0]           rsp_avg_jitter,
   output logic [fijm_pkg::COUNT_OUT_W-1:0]      rsp_interval_count,
   output logic                                  rsp_interval_warn,
   output logic                                  rsp_jitter_warn,
   output logic                                  rsp_no_frames_error,
   output logic                                  rsp_store_full,
   output logic                                  rsp_is_report
);
   import fijm_pkg::*;

   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_INTERVALS);

   logic [CFG_W-1:0]  period_ff, thresh_ff;
   logic [DATA_W-1:0] t_ff, prev_arr_ff, prev_int_ff, iv_ff;
   logic [DATA_W-1:0] min_int_ff, max_int_ff, min_jit_ff, max_jit_ff;
   logic [DATA_W-1:0] j1_ff, j2_ff, j_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CW-1:0]     count_ff, count_inc, count_less1;
   logic              eot_ff, started_ff, full_ff, iv_valid_ff, jit_en_ff;
   logic              out_valid_ff, out_free;
   logic [DATA_W-1:0] period_x, thresh_x, j1_calc, j2_calc, spread;
   logic [SUM_W-1:0]  quotient;
   logic              div_done, has_iv, clear_test;
   logic [CW+COUNT_OUT_W-1:0] count_wide;

   logic [DATA_W-1:0]      o_iv_ff, o_min_int_ff, o_max_int_ff;
   logic [DATA_W-1:0]      o_min_jit_ff, o_max_jit_ff, o_avg_ff;
   logic [COUNT_OUT_W-1:0] o_count_ff;
   logic                   o_iwarn_ff, o_jwarn_ff, o_nof_ff, o_full_ff, o_rep_ff;

   assign period_x    = {{(DATA_W-CFG_W){1'b0}}, period_ff};
   assign thresh_x    = {{(DATA_W-CFG_W){1'b0}}, thresh_ff};
   assign count_inc   = count_ff + CW'(1);
   assign count_less1 = count_ff - CW'(1);
   assign j1_calc     = (iv_ff >= prev_int_ff) ? iv_ff - prev_int_ff : prev_int_ff - iv_ff;
   assign j2_calc     = (period_x >= iv_ff) ? period_x - iv_ff : iv_ff - period_x;
   assign spread      = max_int_ff - min_int_ff;
   assign has_iv      = count_ff != '0;
   assign count_wide  = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign clear_test  = cmd.load_out && eot_ff;

   fijm_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_less1),
      .quotient (quotient),
      .done     (div_done)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= FRAME_PERIOD_RST;
         thresh_ff <= WARN_THRESH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_PERIOD: period_ff <= csr_wdata;
            CSR_WARN_THRESH:  thresh_ff <= csr_wdata;
            default:          period_ff <= period_ff;
         endcase
      end
   end

   // input word and per-item scratch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t_ff   <= req_arrival_usec;
         eot_ff <= req_end_of_test;
      end
      if (cmd.calc_iv) iv_ff <= t_ff - prev_arr_ff;
      if (cmd.rec_iv) begin
         j1_ff <= j1_calc;
         j2_ff <= j2_calc;
      end
      if (cmd.calc_jmax) j_ff <= (j1_ff > j2_ff) ? j1_ff : j2_ff;
   end

   // test statistics
   always_ff @(posedge clock) begin
      if (reset || clear_test) begin
         started_ff  <= 1'b0;
         prev_arr_ff <= '0;
         prev_int_ff <= '0;
         count_ff    <= '0;
         min_int_ff  <= '0;
         max_int_ff  <= '0;
         min_jit_ff  <= JIT_MIN_START;
         max_jit_ff  <= '0;
         sum_ff      <= '0;
         full_ff     <= 1'b0;
         iv_valid_ff <= 1'b0;
         jit_en_ff   <= 1'b0;
      end else begin
         if (cmd.capture) iv_valid_ff <= 1'b0;
         if (cmd.first_arr) begin
            started_ff  <= 1'b1;
            prev_arr_ff <= t_ff;
            min_int_ff  <= period_x;
         end
         if (cmd.rec_iv) begin
            prev_arr_ff <= t_ff;
            prev_int_ff <= iv_ff;
            if (iv_ff < min_int_ff) min_int_ff <= iv_ff;
            if (iv_ff > max_int_ff) max_int_ff <= iv_ff;
            jit_en_ff   <= has_iv;
            count_ff    <= count_inc;
            full_ff     <= count_inc >= COUNT_LIMIT;
            iv_valid_ff <= 1'b1;
         end
         // jitter only from the second interval on
         if (cmd.rec_jit && jit_en_ff) begin
            if (j_ff < min_jit_ff) min_jit_ff <= j_ff;
            if (j_ff > max_jit_ff) max_jit_ff <= j_ff;
            sum_ff <= sum_ff + {{(SUM_W-DATA_W){1'b0}}, j_ff};
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         o_iv_ff      <= iv_valid_ff ? iv_ff : '0;
         o_min_int_ff <= min_int_ff;
         o_max_int_ff <= max_int_ff;
         o_min_jit_ff <= min_jit_ff;
         o_max_jit_ff <= max_jit_ff;
         o_avg_ff     <= (eot_ff && count_ff >= CW'(2)) ? quotient[DATA_W-1:0] : '0;
         o_count_ff   <= count_wide[COUNT_OUT_W-1:0];
         o_iwarn_ff   <= eot_ff && has_iv && (spread >= thresh_x);
         o_jwarn_ff   <= eot_ff && has_iv && (max_jit_ff >= thresh_x);
         o_nof_ff     <= eot_ff && !has_iv;
         o_full_ff    <= full_ff;
         o_rep_ff     <= eot_ff;
      end
   end

   always_comb begin
      stat.eot       = eot_ff;
      stat.full      = full_ff;
      stat.started   = started_ff;
      stat.count_ge2 = count_ff >= CW'(2);
      stat.div_done  = div_done;
      stat.out_free  = out_free;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_interval_usec   = o_iv_ff;
   assign rsp_min_interval    = o_min_int_ff;
   assign rsp_max_interval    = o_max_int_ff;
   assign rsp_min_jitter      = o_min_jit_ff;
   assign rsp_max_jitter      = o_max_jit_ff;
   assign rsp_avg_jitter      = o_avg_ff;
   assign rsp_interval_count  = o_count_ff;
   assign rsp_interval_warn   = o_iwarn_ff;
   assign rsp_jitter_warn     = o_jwarn_ff;
   assign rsp_no_frames_error = o_nof_ff;
   assign rsp_store_full      = o_full_ff;
   assign rsp_is_report       = o_rep_ff;
endmodule

### design/frame_interval_jitter_monitor.sv
// Frame interval and jitter monitor. Each request word is a frame arrival time
// in microseconds or an end-of-test request, and each gives one response word.
// An arrival goes from decode straight to deliver when it is the first of a
// test, is ignored or the store is full; when it records an interval, the
// interval subtract, the absolute differences, their maximum and the jitter
// update run in separate controller steps before deliver. A report goes
// straight to deliver, or first through the bit-serial average divider
// (48 divider steps) when it has two or more intervals.
// The controller returns to idle as the response is loaded.
// A new request is taken while the previous response still waits on rsp_stall;
// it is held only if it finishes first.
// The report clears all statistics; configuration is kept.
// depends on fijm_pkg, fijm_ctrl, fijm_dp
module frame_interval_jitter_monitor #(
   parameter int MAX_INTERVALS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fijm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fijm_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fijm_pkg::DATA_W-1:0]       req_arrival_usec,
   input  logic                              req_end_of_test,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fijm_pkg::DATA_W-1:0]       rsp_interval_usec,
   output logic [fijm_pkg::DATA_W-1:0]       rsp_min_interval,
   output logic [fijm_pkg::DATA_W-1:0]       rsp_max_interval,
   output logic [fijm_pkg::DATA_W-1:0]       rsp_min_jitter,
   output logic [fijm_pkg::DATA_W-1:0]       rsp_max_jitter,
   output logic [fijm_pkg::DATA_W-1:0]       rsp_avg_jitter,
   output logic [fijm_pkg::COUNT_OUT_W-1:0]  rsp_interval_count,
   output logic                              rsp_interval_warn,
   output logic                              rsp_jitter_warn,
   output logic                              rsp_no_frames_error,
   output logic                              rsp_store_full,
   output logic                              rsp_is_report
);
   import fijm_pkg::*;

   fijm_cmd_type  cmd;
   fijm_stat_type stat;

   fijm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fijm_dp #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_arrival_usec    (req_arrival_usec),
      .req_end_of_test     (req_end_of_test),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_interval_usec   (rsp_interval_usec),
      .rsp_min_interval    (rsp_min_interval),
      .rsp_max_interval    (rsp_max_interval),
      .rsp_min_jitter      (rsp_min_jitter),
      .rsp_max_jitter      (rsp_max_jitter),
      .rsp_avg_jitter      (rsp_avg_jitter),
      .rsp_interval_count  (rsp_interval_count),
      .rsp_interval_warn   (rsp_interval_warn),
      .rsp_jitter_warn     (rsp_jitter_warn),
      .rsp_no_frames_error (rsp_no_frames_error),
      .rsp_store_full      (rsp_store_full),
      .rsp_is_report       (rsp_is_report)
   );

   // one word in flight: the block is busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a word was still in flight");

   // no-frames error only on an empty report
   a_nof_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_frames_error |->
         rsp_is_report && rsp_interval_count == '0 && !rsp_interval_warn && !rsp_jitter_warn)
      else $error("no-frames error on a non-empty or non-report word");

   // average is only carried by reports
   a_avg_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_report |-> rsp_avg_jitter == '0 && !rsp_interval_warn)
      else $error("report fields set on an arrival word");
endmodule
